// ===== rtl/core/asg_pkg.sv =====
// shared types and constants for the allreduce schedule generator
`timescale 1ns / 1ps
`default_nettype none

package asg_pkg;

    localparam int unsigned MAX_RANKS = 64;

    localparam int unsigned CNT_W  = 31;
    localparam int unsigned BYTE_W = 7;
    localparam int unsigned RANK_W = 6;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned IDX_W  = 7;
    localparam int unsigned PROD_W = CNT_W + IDX_W;

    localparam logic [1:0] ACT_COPY   = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_RECV   = 2'd2;
    localparam logic [1:0] ACT_REDUCE = 2'd3;

    localparam logic [1:0] BUF_USER   = 2'd0;
    localparam logic [1:0] BUF_RESULT = 2'd1;
    localparam logic [1:0] BUF_TEMP   = 2'd2;

    localparam logic [1:0] CFG_MY_RANK    = 2'd0;
    localparam logic [1:0] CFG_GROUP_SIZE = 2'd1;
    localparam logic [1:0] CFG_SHORT_MSG  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [RANK_W-1:0] peer;
        logic [1:0]        src_buf;
        logic [1:0]        dst_buf;
        logic [CNT_W-1:0]  elem_offset;
        logic [CNT_W-1:0]  elem_length;
        logic              wait_after;
    } sched_entry_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] a;
        logic [CNT_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic push;
        logic finish;
    } ob_ctrl_t;

    typedef struct packed {
        logic ack;
        logic pend_valid;
    } ob_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/asg_mul.sv =====
// shared registered multiplier for offsets, lengths and the byte size
`timescale 1ns / 1ps
`default_nettype none

module asg_mul (
    input  wire logic                       aclk,
    input  wire asg_pkg::mul_req_t          req,
    output logic [asg_pkg::PROD_W-1:0]      prod
);
    import asg_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = {{(PROD_W-IDX_W){1'b0}}, req.a} * {{(PROD_W-CNT_W){1'b0}}, req.b};

    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/asg_out_buf.sv =====
// pending entry stage and output register, marks the final entry of a run
`timescale 1ns / 1ps
`default_nettype none

module asg_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire asg_pkg::ob_ctrl_t     ctrl,
    input  wire asg_pkg::sched_entry_t entry_in,
    output asg_pkg::ob_stat_t          stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output asg_pkg::sched_entry_t      m_entry,
    output logic                       m_last
);
    import asg_pkg::*;

    logic         pend_valid_reg, pend_valid_next;
    sched_entry_t pend_reg, pend_next;
    logic         out_valid_reg, out_valid_next;
    sched_entry_t out_reg, out_next;
    logic         last_reg, last_next;
    logic         out_free;
    logic         ack;
    logic         move;

    assign out_free = !out_valid_reg || m_ready;
    assign ack      = !pend_valid_reg || out_free;
    assign move     = (ctrl.push || ctrl.finish) && ack && pend_valid_reg;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (move) begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            last_next      = ctrl.finish;
        end
        if (ctrl.push && ack) begin
            pend_valid_next = 1'b1;
            pend_next       = entry_in;
        end else if (ctrl.finish && ack) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign stat.ack        = ack;
    assign stat.pend_valid = pend_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_entry         = out_reg;
    assign m_last          = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/asg_ctrl.sv =====
// schedule sequencer: walks fold, doubling or scatter/gather steps, drives the multiplier
`timescale 1ns / 1ps
`default_nettype none

module asg_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [asg_pkg::CNT_W-1:0]    s_element_count,
    input  wire logic [asg_pkg::BYTE_W-1:0]   s_element_bytes,
    input  wire logic                         s_op_commutative,
    input  wire logic                         s_op_builtin,
    input  wire logic                         s_inplace,
    input  wire logic [asg_pkg::RANK_W-1:0]   my_rank,
    input  wire logic [asg_pkg::SIZE_W-1:0]   group_size,
    input  wire logic [31:0]                  short_msg_bytes,
    output asg_pkg::mul_req_t                 mul_req,
    input  wire logic [asg_pkg::PROD_W-1:0]   mul_prod,
    output asg_pkg::ob_ctrl_t                 ob_ctrl,
    input  wire asg_pkg::ob_stat_t            ob_stat,
    output asg_pkg::sched_entry_t             ob_entry
);
    import asg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP  = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_PLAN   = 7'b0001000,
        ST_OFF    = 7'b0010000,
        ST_LEN    = 7'b0100000,
        ST_FLUSH  = 7'b1000000
    } ctrl_state_t;

    typedef enum logic [6:0] {
        PH_COPY = 7'b0000001,
        PH_PRE  = 7'b0000010,
        PH_RD   = 7'b0000100,
        PH_RS   = 7'b0001000,
        PH_AG   = 7'b0010000,
        PH_POST = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        LEN_ZERO,
        LEN_TAIL,
        LEN_MID
    } len_mode_t;

    ctrl_state_t       state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic [2:0]        j_reg, j_next;
    logic [IDX_W-1:0]  sidx_reg, sidx_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [IDX_W-1:0]  lidx_reg, lidx_next;
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] ebytes_reg;
    logic              commut_reg;
    logic              builtin_reg;
    logic              inplace_reg;
    logic              use_rd_reg, use_rd_next;
    logic [CNT_W-1:0]  q_reg, q_next;
    sched_entry_t      desc_reg, desc_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    len_mode_t         len_mode_reg, len_mode_next;
    logic [IDX_W-1:0]  len_m_reg, len_m_next;

    logic [SIZE_W-1:0] size_eff;
    logic [2:0]        log_k;
    logic [2:0]        k_m1;
    logic [IDX_W-1:0]  pof2;
    logic [SIZE_W-1:0] rem;
    logic              rank_ok;
    logic              fold;
    logic [RANK_W-1:0] newrank;
    logic              main_on;
    logic [RANK_W-1:0] mask_j;
    logic [RANK_W-1:0] nd;
    logic [RANK_W-1:0] rd_peer;
    logic              peer_lt_rank;
    logic              lower;
    logic [2:0]        jp1;
    logic [IDX_W-1:0]  half;
    logic [IDX_W-1:0]  cur_s, cur_r, cur_l;
    phase_t            enter_main;

    logic              p_emit;
    logic [1:0]        p_action;
    logic [RANK_W-1:0] p_peer;
    logic [1:0]        p_src;
    logic [1:0]        p_dst;
    logic              p_wait;
    logic [IDX_W-1:0]  p_off_idx;
    logic [IDX_W-1:0]  p_span_a;
    logic [IDX_W-1:0]  p_span_b;
    phase_t            p_phase;
    logic [1:0]        p_sub;
    logic [2:0]        p_j;
    logic [IDX_W-1:0]  p_sidx, p_ridx, p_lidx;
    len_mode_t         p_len_mode;
    logic [IDX_W-1:0]  p_len_m;
    logic [CNT_W-1:0]  len_val;

    // group geometry
    always_comb begin
        if (group_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (32'(group_size) > 32'(MAX_RANKS)) begin
            size_eff = SIZE_W'(MAX_RANKS);
        end else begin
            size_eff = group_size;
        end
        log_k = 3'd0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_eff[i]) begin
                log_k = 3'(i);
            end
        end
    end

    assign pof2    = IDX_W'(1) << log_k;
    assign k_m1    = log_k - 3'd1;
    assign rem     = size_eff - pof2;
    assign rank_ok = {1'b0, my_rank} < size_eff;
    assign fold    = {1'b0, my_rank} < {rem[RANK_W-1:0], 1'b0};
    assign newrank = fold ? {1'b0, my_rank[RANK_W-1:1]} : my_rank - rem[RANK_W-1:0];
    assign main_on = !(fold && !my_rank[0]);

    assign mask_j  = RANK_W'(1) << j_reg;
    assign nd      = newrank ^ mask_j;
    assign rd_peer = ({1'b0, nd} < rem) ? {nd[RANK_W-2:0], 1'b1} : nd + rem[RANK_W-1:0];
    assign peer_lt_rank = rd_peer < my_rank;
    assign lower   = (newrank & mask_j) == '0;
    assign jp1     = j_reg + 3'd1;
    assign half    = pof2 >> jp1;

    assign enter_main = (!main_on || log_k == 3'd0) ? PH_POST : (use_rd_reg ? PH_RD : PH_RS);

    // block indexes after the update at the head of an exchange step
    always_comb begin
        cur_s = sidx_reg;
        cur_r = ridx_reg;
        cur_l = lidx_reg;
        if (sub_reg == 2'd0) begin
            if (phase_reg == PH_RS) begin
                if (lower) begin
                    cur_s = ridx_reg + half;
                end else begin
                    cur_r = sidx_reg + half;
                end
            end else if (phase_reg == PH_AG) begin
                if (lower) begin
                    cur_r = sidx_reg + half;
                    if (j_reg != k_m1) begin
                        cur_l = lidx_reg + half;
                    end
                end else begin
                    cur_r = sidx_reg - half;
                end
            end
        end
    end

    // entry decode for the current step
    always_comb begin
        p_emit    = 1'b0;
        p_action  = ACT_COPY;
        p_peer    = '0;
        p_src     = BUF_USER;
        p_dst     = BUF_USER;
        p_wait    = 1'b0;
        p_off_idx = '0;
        p_span_a  = '0;
        p_span_b  = pof2;
        p_phase   = phase_reg;
        p_sub     = sub_reg;
        p_j       = j_reg;
        p_sidx    = cur_s;
        p_ridx    = cur_r;
        p_lidx    = cur_l;
        unique case (phase_reg)
            PH_COPY: begin
                p_emit   = !inplace_reg;
                p_action = ACT_COPY;
                p_src    = BUF_USER;
                p_dst    = BUF_RESULT;
                p_wait   = 1'b1;
                p_phase  = PH_PRE;
            end
            PH_PRE: begin
                if (fold && my_rank[0]) begin
                    p_emit = 1'b1;
                    p_wait = 1'b1;
                    if (sub_reg == 2'd0) begin
                        p_action = ACT_RECV;
                        p_peer   = my_rank - RANK_W'(1);
                        p_dst    = BUF_TEMP;
                        p_sub    = 2'd1;
                    end else begin
                        p_action = ACT_REDUCE;
                        p_src    = BUF_TEMP;
                        p_dst    = BUF_RESULT;
                        p_sub    = 2'd0;
                        p_phase  = enter_main;
                    end
                end else if (fold) begin
                    p_emit   = 1'b1;
                    p_action = ACT_SEND;
                    p_peer   = my_rank + RANK_W'(1);
                    p_src    = BUF_RESULT;
                    p_wait   = 1'b1;
                    p_phase  = enter_main;
                end else begin
                    p_phase = enter_main;
                end
            end
            PH_RD: begin
                p_emit = 1'b1;
                unique case (sub_reg)
                    2'd0: begin
                        p_action = ACT_RECV;
                        p_peer   = rd_peer;
                        p_dst    = BUF_TEMP;
                        p_sub    = 2'd1;
                    end
                    2'd1: begin
                        p_action = ACT_SEND;
                        p_peer   = rd_peer;
                        p_src    = BUF_RESULT;
                        p_wait   = 1'b1;
                        p_sub    = 2'd2;
                    end
                    2'd2: begin
                        p_action = ACT_REDUCE;
                        p_wait   = 1'b1;
                        if (commut_reg || peer_lt_rank) begin
                            p_src = BUF_TEMP;
                            p_dst = BUF_RESULT;
                            p_sub = 2'd0;
                            if (j_reg == k_m1) begin
                                p_phase = PH_POST;
                            end else begin
                                p_j = jp1;
                            end
                        end else begin
                            p_src = BUF_RESULT;
                            p_dst = BUF_TEMP;
                            p_sub = 2'd3;
                        end
                    end
                    2'd3: begin
                        p_action = ACT_COPY;
                        p_src    = BUF_TEMP;
                        p_dst    = BUF_RESULT;
                        p_wait   = 1'b1;
                        p_sub    = 2'd0;
                        if (j_reg == k_m1) begin
                            p_phase = PH_POST;
                        end else begin
                            p_j = jp1;
                        end
                    end
                endcase
            end
            PH_RS: begin
                p_emit = 1'b1;
                unique case (sub_reg)
                    2'd0: begin
                        p_action  = ACT_RECV;
                        p_peer    = rd_peer;
                        p_dst     = BUF_TEMP;
                        p_off_idx = cur_r;
                        p_span_a  = cur_r;
                        p_span_b  = lower ? cur_s : cur_l;
                        p_sub     = 2'd1;
                    end
                    2'd1: begin
                        p_action  = ACT_SEND;
                        p_peer    = rd_peer;
                        p_src     = BUF_RESULT;
                        p_wait    = 1'b1;
                        p_off_idx = cur_s;
                        p_span_a  = cur_s;
                        p_span_b  = lower ? cur_l : cur_r;
                        p_sub     = 2'd2;
                    end
                    default: begin
                        p_action  = ACT_REDUCE;
                        p_src     = BUF_TEMP;
                        p_dst     = BUF_RESULT;
                        p_wait    = 1'b1;
                        p_off_idx = cur_r;
                        p_span_a  = cur_r;
                        p_span_b  = lower ? cur_s : cur_l;
                        p_sub     = 2'd0;
                        p_sidx    = ridx_reg;
                        if (j_reg == k_m1) begin
                            p_phase = PH_AG;
                        end else begin
                            p_lidx = ridx_reg + half;
                            p_j    = jp1;
                        end
                    end
                endcase
            end
            PH_AG: begin
                p_emit = 1'b1;
                if (sub_reg == 2'd0) begin
                    p_action  = ACT_RECV;
                    p_peer    = rd_peer;
                    p_dst     = BUF_RESULT;
                    p_off_idx = cur_r;
                    p_span_a  = cur_r;
                    p_span_b  = lower ? cur_l : sidx_reg;
                    p_sub     = 2'd1;
                end else begin
                    p_action  = ACT_SEND;
                    p_peer    = rd_peer;
                    p_src     = BUF_RESULT;
                    p_wait    = 1'b1;
                    p_off_idx = sidx_reg;
                    p_span_a  = sidx_reg;
                    p_span_b  = lower ? cur_r : cur_l;
                    p_sub     = 2'd0;
                    if (!lower) begin
                        p_sidx = ridx_reg;
                    end
                    if (j_reg == 3'd0) begin
                        p_phase = PH_POST;
                    end else begin
                        p_j = j_reg - 3'd1;
                    end
                end
            end
            PH_POST: begin
                p_emit  = fold;
                p_phase = PH_DONE;
                if (my_rank[0]) begin
                    p_action = ACT_SEND;
                    p_peer   = my_rank - RANK_W'(1);
                    p_src    = BUF_RESULT;
                end else begin
                    p_action = ACT_RECV;
                    p_peer   = my_rank + RANK_W'(1);
                    p_dst    = BUF_RESULT;
                end
            end
            PH_DONE: begin
                p_emit = 1'b0;
            end
            default: begin
                p_emit = 1'b0;
            end
        endcase
    end

    // span of blocks [a, b): empty, tail up to the total, or whole blocks
    always_comb begin
        if (p_span_b <= p_span_a) begin
            p_len_mode = LEN_ZERO;
            p_len_m    = '0;
        end else if (p_span_b >= pof2) begin
            p_len_mode = LEN_TAIL;
            p_len_m    = p_span_a;
        end else begin
            p_len_mode = LEN_MID;
            p_len_m    = p_span_b - p_span_a;
        end
    end

    always_comb begin
        unique case (len_mode_reg)
            LEN_ZERO: len_val = '0;
            LEN_TAIL: len_val = count_reg - mul_prod[CNT_W-1:0];
            LEN_MID:  len_val = mul_prod[CNT_W-1:0];
            default:  len_val = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        sub_next      = sub_reg;
        j_next        = j_reg;
        sidx_next     = sidx_reg;
        ridx_next     = ridx_reg;
        lidx_next     = lidx_reg;
        use_rd_next   = use_rd_reg;
        q_next        = q_reg;
        desc_next     = desc_reg;
        off_next      = off_reg;
        len_mode_next = len_mode_reg;
        len_m_next    = len_m_reg;
        mul_req.start = 1'b0;
        mul_req.a     = len_m_reg;
        mul_req.b     = q_reg;
        ob_ctrl.push   = 1'b0;
        ob_ctrl.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                mul_req.start = 1'b1;
                mul_req.a     = ebytes_reg;
                mul_req.b     = count_reg;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                use_rd_next = (mul_prod <= {{(PROD_W-32){1'b0}}, short_msg_bytes}) ||
                              !builtin_reg ||
                              (count_reg < {{(CNT_W-IDX_W){1'b0}}, pof2});
                q_next     = count_reg >> log_k;
                phase_next = PH_COPY;
                sub_next   = 2'd0;
                j_next     = 3'd0;
                sidx_next  = '0;
                ridx_next  = '0;
                lidx_next  = pof2;
                state_next = rank_ok ? ST_PLAN : ST_FLUSH;
            end
            ST_PLAN: begin
                phase_next = p_phase;
                sub_next   = p_sub;
                j_next     = p_j;
                sidx_next  = p_sidx;
                ridx_next  = p_ridx;
                lidx_next  = p_lidx;
                if (phase_reg == PH_DONE) begin
                    state_next = ST_FLUSH;
                end else if (p_emit) begin
                    desc_next.action      = p_action;
                    desc_next.peer        = p_peer;
                    desc_next.src_buf     = p_src;
                    desc_next.dst_buf     = p_dst;
                    desc_next.elem_offset = '0;
                    desc_next.elem_length = '0;
                    desc_next.wait_after  = p_wait;
                    len_mode_next = p_len_mode;
                    len_m_next    = p_len_m;
                    mul_req.start = 1'b1;
                    mul_req.a     = p_off_idx;
                    mul_req.b     = q_reg;
                    state_next    = ST_OFF;
                end
            end
            ST_OFF: begin
                off_next      = mul_prod[CNT_W-1:0];
                mul_req.start = 1'b1;
                mul_req.a     = len_m_reg;
                mul_req.b     = q_reg;
                state_next    = ST_LEN;
            end
            ST_LEN: begin
                ob_ctrl.push = 1'b1;
                if (ob_stat.ack) begin
                    state_next = ST_PLAN;
                end
            end
            ST_FLUSH: begin
                ob_ctrl.finish = 1'b1;
                if (ob_stat.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DONE;
            sub_reg   <= 2'd0;
            j_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            j_reg     <= j_next;
        end
        if (state_reg == ST_IDLE && s_valid) begin
            count_reg   <= s_element_count;
            ebytes_reg  <= s_element_bytes;
            commut_reg  <= s_op_commutative;
            builtin_reg <= s_op_builtin;
            inplace_reg <= s_inplace;
        end
        sidx_reg     <= sidx_next;
        ridx_reg     <= ridx_next;
        lidx_reg     <= lidx_next;
        use_rd_reg   <= use_rd_next;
        q_reg        <= q_next;
        desc_reg     <= desc_next;
        off_reg      <= off_next;
        len_mode_reg <= len_mode_next;
        len_m_reg    <= len_m_next;
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ob_entry             = desc_reg;
        ob_entry.elem_offset = off_reg;
        ob_entry.elem_length = len_val;
    end

endmodule

`default_nettype wire

// ===== rtl/core/allreduce_schedule_generator.sv =====
// allreduce schedule generator top level: configuration registers and submodules
//
// One request on the s_ channel describes an allreduce; the block answers with
// the run of schedule entries for this node on the m_ channel, the final one
// flagged by m_last. A run holds 0 to 31 entries.
// Rank, group size and the short message threshold are written through the
// cfg_ port (cfg_wr_en, cfg_index, cfg_data), one register per cycle. The
// user must write them only while no request is in flight; the block
// itself does not enforce it. After a request is accepted, the setup states
// form the byte size product through the shared multiplier; then each entry
// is planned, and its element offset product and then its length product are
// formed, all on the single 7x31 multiplier. Phases that emit nothing pass
// through the planning state without an entry. s_ready is high only between
// requests.
// The last entry of a run is held one stage back until the run ends, then
// leaves with m_last set. The output register lets the next request start
// while the final entry still waits for m_ready; a stalled receiver holds
// the sequencer at its next entry.
// Reset (synchronous, aresetn low) restores rank 0, group size 1 and a
// threshold of 2048 bytes, and drops any entry in flight.
`timescale 1ns / 1ps
`default_nettype none

module allreduce_schedule_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [30:0] s_element_count,
    input  wire logic [6:0]  s_element_bytes,
    input  wire logic        s_op_commutative,
    input  wire logic        s_op_builtin,
    input  wire logic        s_inplace,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_action,
    output logic [5:0]       m_peer,
    output logic [1:0]       m_src_buf,
    output logic [1:0]       m_dst_buf,
    output logic [30:0]      m_elem_offset,
    output logic [30:0]      m_elem_length,
    output logic             m_wait_after,
    output logic             m_last
);
    import asg_pkg::*;

    logic [RANK_W-1:0] my_rank_reg, my_rank_next;
    logic [SIZE_W-1:0] group_size_reg, group_size_next;
    logic [31:0]       short_msg_bytes_reg, short_msg_bytes_next;

    mul_req_t          mul_req;
    logic [PROD_W-1:0] mul_prod;
    ob_ctrl_t          ob_ctrl;
    ob_stat_t          ob_stat;
    sched_entry_t      ob_entry;
    sched_entry_t      m_entry;

    always_comb begin
        my_rank_next         = my_rank_reg;
        group_size_next      = group_size_reg;
        short_msg_bytes_next = short_msg_bytes_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MY_RANK:    my_rank_next         = cfg_data[RANK_W-1:0];
                CFG_GROUP_SIZE: group_size_next      = cfg_data[SIZE_W-1:0];
                CFG_SHORT_MSG:  short_msg_bytes_next = cfg_data;
                default: begin
                    my_rank_next = my_rank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_rank_reg         <= '0;
            group_size_reg      <= SIZE_W'(1);
            short_msg_bytes_reg <= 32'd2048;
        end else begin
            my_rank_reg         <= my_rank_next;
            group_size_reg      <= group_size_next;
            short_msg_bytes_reg <= short_msg_bytes_next;
        end
    end

    asg_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    asg_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_count  (s_element_count),
        .s_element_bytes  (s_element_bytes),
        .s_op_commutative (s_op_commutative),
        .s_op_builtin     (s_op_builtin),
        .s_inplace        (s_inplace),
        .my_rank          (my_rank_reg),
        .group_size       (group_size_reg),
        .short_msg_bytes  (short_msg_bytes_reg),
        .mul_req          (mul_req),
        .mul_prod         (mul_prod),
        .ob_ctrl          (ob_ctrl),
        .ob_stat          (ob_stat),
        .ob_entry         (ob_entry)
    );

    asg_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ob_ctrl),
        .entry_in (ob_entry),
        .stat     (ob_stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_entry  (m_entry),
        .m_last   (m_last)
    );

    assign m_action      = m_entry.action;
    assign m_peer        = m_entry.peer;
    assign m_src_buf     = m_entry.src_buf;
    assign m_dst_buf     = m_entry.dst_buf;
    assign m_elem_offset = m_entry.elem_offset;
    assign m_elem_length = m_entry.elem_length;
    assign m_wait_after  = m_entry.wait_after;

`ifndef NO_ASSERTIONS
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_accept_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ob_stat.pend_valid)
        else $error("new request taken while an entry is still pending");

    a_local_peer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_COPY || m_action == ACT_REDUCE) |-> m_peer == '0)
        else $error("local entry carries a peer");

    a_send_no_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ACT_SEND |-> m_dst_buf == BUF_USER)
        else $error("send entry carries a destination buffer");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the allreduce schedule generator: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import asg_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 128;

    typedef struct packed {
        logic [30:0] count;
        logic [6:0]  bytes;
        logic        commut;
        logic        builtin;
        logic        inplace;
    } req_t;

    typedef struct packed {
        sched_entry_t entry;
        logic         last;
    } sched_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_MY_RANK;
    logic [31:0] cfg_data = 32'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [30:0] s_element_count = 31'd0;
    logic [6:0]  s_element_bytes = 7'd1;
    logic        s_op_commutative = 1'b0;
    logic        s_op_builtin = 1'b0;
    logic        s_inplace = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_action;
    logic [5:0]  m_peer;
    logic [1:0]  m_src_buf;
    logic [1:0]  m_dst_buf;
    logic [30:0] m_elem_offset;
    logic [30:0] m_elem_length;
    logic        m_wait_after;
    logic        m_last;

    // shadow copy of the configuration registers
    logic [5:0]  cfg_rank = 6'd0;
    logic [6:0]  cfg_group = 7'd1;
    logic [31:0] cfg_short = 32'd2048;

    req_t        pending_reqs[$];
    sched_beat_t expected_entries[$];
    req_t        drive_req;
    req_t        taken_req;
    sched_beat_t want;
    logic        req_accepted = 1'b0;
    int          send_idle_pct = 31;
    int          recv_idle_pct = 47;
    int          n_queued = 0;
    int          n_taken = 0;
    int          n_entries = 0;
    int          n_configs = 0;
    int          n_rsag = 0;
    int          errors = 0;
    int          cycle_count = 0;

    allreduce_schedule_generator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_element_count  (s_element_count),
        .s_element_bytes  (s_element_bytes),
        .s_op_commutative (s_op_commutative),
        .s_op_builtin     (s_op_builtin),
        .s_inplace        (s_inplace),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_peer           (m_peer),
        .m_src_buf        (m_src_buf),
        .m_dst_buf        (m_dst_buf),
        .m_elem_offset    (m_elem_offset),
        .m_elem_length    (m_elem_length),
        .m_wait_after     (m_wait_after),
        .m_last           (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("allreduce_schedule_generator: mismatch");
            $finish;
        end
    end

    function automatic void add_entry(input logic [1:0] act, input longint peer,
                                      input logic [1:0] src, input logic [1:0] dst,
                                      input longint off, input longint len,
                                      input logic wt);
        sched_beat_t b;
        b.entry.action      = act;
        b.entry.peer        = peer[5:0];
        b.entry.src_buf     = src;
        b.entry.dst_buf     = dst;
        b.entry.elem_offset = off[30:0];
        b.entry.elem_length = len[30:0];
        b.entry.wait_after  = wt;
        b.last              = 1'b0;
        expected_entries.push_back(b);
    endfunction

    // elements in blocks [a, b); the last block takes the remainder
    function automatic longint chunk_len(input longint a, input longint b, input longint pof2,
                                         input longint q, input longint total);
        if (b <= a) return 0;
        if (b >= pof2) return total - a * q;
        return (b - a) * q;
    endfunction

    function automatic longint peer_of(input longint nd, input longint rem);
        return (nd < rem) ? nd * 2 + 1 : nd + rem;
    endfunction

    function automatic void plan_schedule(input req_t r);
        longint cnt, size, rank, pof2, rem, newrank, mask, nd, dst, q;
        longint sidx, ridx, lidx, scnt, rcnt;
        logic use_rd;
        int n0;
        sched_beat_t tail;
        cnt  = longint'(r.count);
        size = longint'(cfg_group);
        rank = longint'(cfg_rank);
        n0   = expected_entries.size();
        if (size < 1) size = 1;
        if (size > MAX_RANKS) size = MAX_RANKS;
        if (rank >= size) return;
        pof2 = 1;
        while (pof2 * 2 <= size) pof2 = pof2 * 2;
        rem = size - pof2;
        use_rd = (cnt * longint'(r.bytes) <= longint'(cfg_short)) || !r.builtin || (cnt < pof2);

        if (!r.inplace) add_entry(ACT_COPY, 0, BUF_USER, BUF_RESULT, 0, cnt, 1'b1);

        // fold the ranks beyond the power of two
        if (rank < 2 * rem) begin
            if (rank % 2 == 0) begin
                add_entry(ACT_SEND, rank + 1, BUF_RESULT, BUF_USER, 0, cnt, 1'b1);
                newrank = -1;
            end else begin
                add_entry(ACT_RECV, rank - 1, BUF_USER, BUF_TEMP, 0, cnt, 1'b1);
                add_entry(ACT_REDUCE, 0, BUF_TEMP, BUF_RESULT, 0, cnt, 1'b1);
                newrank = rank / 2;
            end
        end else begin
            newrank = rank - rem;
        end

        if (newrank >= 0 && use_rd) begin
            for (mask = 1; mask < pof2; mask = mask * 2) begin
                nd  = newrank ^ mask;
                dst = peer_of(nd, rem);
                add_entry(ACT_RECV, dst, BUF_USER, BUF_TEMP, 0, cnt, 1'b0);
                add_entry(ACT_SEND, dst, BUF_RESULT, BUF_USER, 0, cnt, 1'b1);
                if (r.commut || dst < rank) begin
                    add_entry(ACT_REDUCE, 0, BUF_TEMP, BUF_RESULT, 0, cnt, 1'b1);
                end else begin
                    add_entry(ACT_REDUCE, 0, BUF_RESULT, BUF_TEMP, 0, cnt, 1'b1);
                    add_entry(ACT_COPY, 0, BUF_TEMP, BUF_RESULT, 0, cnt, 1'b1);
                end
            end
        end else if (newrank >= 0) begin
            n_rsag++;
            sidx = 0;
            ridx = 0;
            lidx = pof2;
            q    = cnt / pof2;
            // reduce-scatter
            mask = 1;
            while (mask < pof2) begin
                nd  = newrank ^ mask;
                dst = peer_of(nd, rem);
                if (newrank < nd) begin
                    sidx = ridx + pof2 / (mask * 2);
                    scnt = chunk_len(sidx, lidx, pof2, q, cnt);
                    rcnt = chunk_len(ridx, sidx, pof2, q, cnt);
                end else begin
                    ridx = sidx + pof2 / (mask * 2);
                    scnt = chunk_len(sidx, ridx, pof2, q, cnt);
                    rcnt = chunk_len(ridx, lidx, pof2, q, cnt);
                end
                add_entry(ACT_RECV, dst, BUF_USER, BUF_TEMP, ridx * q, rcnt, 1'b0);
                add_entry(ACT_SEND, dst, BUF_RESULT, BUF_USER, sidx * q, scnt, 1'b1);
                add_entry(ACT_REDUCE, 0, BUF_TEMP, BUF_RESULT, ridx * q, rcnt, 1'b1);
                sidx = ridx;
                mask = mask * 2;
                if (mask < pof2) lidx = ridx + pof2 / mask;
            end
            // allgather
            for (mask = mask / 2; mask > 0; mask = mask / 2) begin
                nd  = newrank ^ mask;
                dst = peer_of(nd, rem);
                if (newrank < nd) begin
                    if (mask != pof2 / 2) lidx = lidx + pof2 / (mask * 2);
                    ridx = sidx + pof2 / (mask * 2);
                    scnt = chunk_len(sidx, ridx, pof2, q, cnt);
                    rcnt = chunk_len(ridx, lidx, pof2, q, cnt);
                end else begin
                    ridx = sidx - pof2 / (mask * 2);
                    scnt = chunk_len(sidx, lidx, pof2, q, cnt);
                    rcnt = chunk_len(ridx, sidx, pof2, q, cnt);
                end
                add_entry(ACT_RECV, dst, BUF_USER, BUF_RESULT, ridx * q, rcnt, 1'b0);
                add_entry(ACT_SEND, dst, BUF_RESULT, BUF_USER, sidx * q, scnt, 1'b1);
                if (newrank > nd) sidx = ridx;
            end
        end

        // hand the result back to the folded partner
        if (rank < 2 * rem) begin
            if (rank % 2 == 1)
                add_entry(ACT_SEND, rank - 1, BUF_RESULT, BUF_USER, 0, cnt, 1'b0);
            else
                add_entry(ACT_RECV, rank + 1, BUF_USER, BUF_RESULT, 0, cnt, 1'b0);
        end

        if (expected_entries.size() > n0) begin
            tail = expected_entries.pop_back();
            tail.last = 1'b1;
            expected_entries.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_val,
                                        input longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    // request driver
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_req = pending_reqs.pop_front();
                s_element_count  <= drive_req.count;
                s_element_bytes  <= drive_req.bytes;
                s_op_commutative <= drive_req.commut;
                s_op_builtin     <= drive_req.builtin;
                s_inplace        <= drive_req.inplace;
                s_valid          <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted request, check each schedule entry
    always @(posedge aclk) begin
        req_accepted = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_req.count   = s_element_count;
                taken_req.bytes   = s_element_bytes;
                taken_req.commut  = s_op_commutative;
                taken_req.builtin = s_op_builtin;
                taken_req.inplace = s_inplace;
                plan_schedule(taken_req);
                n_taken++;
                req_accepted = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_entries.size() == 0) begin
                    $display("%0t: unexpected entry action %0d peer %0d offset %0d length %0d",
                             $time, m_action, m_peer, m_elem_offset, m_elem_length);
                    errors++;
                end else begin
                    want = expected_entries.pop_front();
                    check_field("action", want.entry.action, m_action);
                    check_field("peer", want.entry.peer, m_peer);
                    check_field("src_buf", want.entry.src_buf, m_src_buf);
                    check_field("dst_buf", want.entry.dst_buf, m_dst_buf);
                    check_field("elem_offset", want.entry.elem_offset, m_elem_offset);
                    check_field("elem_length", want.entry.elem_length, m_elem_length);
                    check_field("wait_after", want.entry.wait_after, m_wait_after);
                    check_field("last", want.last, m_last);
                    n_entries++;
                end
            end
        end
    end

    task automatic queue_req(input logic [30:0] count, input logic [6:0] bytes,
                             input logic commut, input logic builtin, input logic inplace);
        req_t r;
        r.count   = count;
        r.bytes   = bytes;
        r.commut  = commut;
        r.builtin = builtin;
        r.inplace = inplace;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // wait until every request is taken and answered, then let a run with no entries finish
    task automatic wait_idle();
        while (n_taken != n_queued || expected_entries.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [5:0] r, input logic [6:0] g, input logic [31:0] th);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MY_RANK;
        cfg_data  <= {26'd0, r};
        cfg_rank  = r;
        @(negedge aclk);
        cfg_index <= CFG_GROUP_SIZE;
        cfg_data  <= {25'd0, g};
        cfg_group = g;
        @(negedge aclk);
        cfg_index <= CFG_SHORT_MSG;
        cfg_data  <= th;
        cfg_short = th;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_configs++;
    endtask

    task automatic random_config();
        logic [6:0]  g;
        logic [5:0]  r;
        logic [31:0] th;
        int eff;
        case ($urandom_range(9))
            0: g = 7'd1 << $urandom_range(6);
            1: g = ($urandom_range(1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
            default: g = 7'($urandom_range(1, 64));
        endcase
        eff = (g == 0) ? 1 : (g > MAX_RANKS) ? MAX_RANKS : g;
        if ($urandom_range(9) == 0) r = 6'($urandom());
        else r = 6'($urandom_range(eff - 1));
        case ($urandom_range(4))
            0: th = 32'd0;
            1: th = 32'd2048;
            2: th = 32'($urandom_range(100000));
            3: th = $urandom();
            default: th = 32'hffff_ffff;
        endcase
        set_config(r, g, th);
    endtask

    function automatic req_t random_req();
        req_t r;
        case ($urandom_range(5))
            0: r.count = 31'($urandom_range(8));
            1: r.count = 31'($urandom_range(300));
            2: r.count = 31'($urandom_range(1 << 20));
            3: r.count = 31'($urandom());
            4: r.count = 31'((1 << $urandom_range(6)) + $urandom_range(2) - 1);
            default: r.count = 31'h7fff_ffff - 31'($urandom_range(3));
        endcase
        r.bytes   = ($urandom_range(7) == 0) ? 7'($urandom()) : 7'($urandom_range(1, 64));
        r.commut  = 1'($urandom_range(1));
        r.builtin = ($urandom_range(4) != 0);
        r.inplace = 1'($urandom_range(1));
        return r;
    endfunction

    initial begin
        req_t r;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: group of one
        queue_req(31'd0, 7'd1, 1'b1, 1'b1, 1'b1);
        queue_req(31'h7fff_ffff, 7'd127, 1'b0, 1'b0, 1'b0);
        // full group, top rank and rank 0, zero threshold
        set_config(6'd63, 7'd64, 32'd0);
        queue_req(31'h7fff_ffff, 7'd64, 1'b1, 1'b1, 1'b0);
        queue_req(31'd100, 7'd0, 1'b1, 1'b1, 1'b1);
        queue_req(31'd1000, 7'd1, 1'b1, 1'b0, 1'b0);
        queue_req(31'd63, 7'd64, 1'b0, 1'b1, 1'b1);
        queue_req(31'd64, 7'd1, 1'b0, 1'b1, 1'b0);
        set_config(6'd0, 7'd64, 32'd0);
        queue_req(31'd1000, 7'd4, 1'b0, 1'b1, 1'b1);
        // folded ranks 4 and 5, unfolded rank 6
        set_config(6'd4, 7'd7, 32'hffff_ffff);
        queue_req(31'd5000, 7'd64, 1'b0, 1'b1, 1'b0);
        set_config(6'd5, 7'd7, 32'd0);
        queue_req(31'd4095, 7'd8, 1'b1, 1'b1, 1'b0);
        queue_req(31'd3, 7'd8, 1'b0, 1'b1, 1'b1);
        set_config(6'd6, 7'd7, 32'd0);
        queue_req(31'd77, 7'd2, 1'b0, 1'b1, 1'b0);
        // group size zero and above the maximum
        set_config(6'd0, 7'd0, 32'd2048);
        queue_req(31'd10, 7'd1, 1'b1, 1'b1, 1'b1);
        queue_req(31'd10, 7'd1, 1'b1, 1'b1, 1'b0);
        set_config(6'd40, 7'd127, 32'd100);
        queue_req(31'd5000, 7'd3, 1'b1, 1'b1, 1'b0);
        queue_req(31'd20, 7'd3, 1'b0, 1'b0, 1'b1);
        // rank outside the group, then the top rank of a group of 63
        set_config(6'd9, 7'd5, 32'd0);
        queue_req(31'd100, 7'd1, 1'b1, 1'b1, 1'b0);
        set_config(6'd62, 7'd63, 32'd0);
        queue_req(31'h4000_0000, 7'd64, 1'b1, 1'b1, 1'b0);
        queue_req(31'd1000, 7'd1, 1'b0, 1'b0, 1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 31 : 0;
            for (int k = 0; k < 6; k++) begin
                random_config();
                for (int i = 0; i < 21; i++) begin
                    r = random_req();
                    queue_req(r.count, r.bytes, r.commut, r.builtin, r.inplace);
                end
            end
        end

        wait_idle();
        $display("%0d requests over %0d register settings, %0d schedule entries checked",
                 n_taken, n_configs, n_entries);
        $display("%0d requests took reduce-scatter and allgather, %0d errors", n_rsag, errors);
        if (errors == 0)
            $display("allreduce_schedule_generator: match");
        else
            $display("allreduce_schedule_generator: mismatch");
        $finish;
    end

endmodule
